// ----- rtl/core/icmp_reply_header_parser_core_assert.svh -----
// ----------------------------------------------------------------------------
// ICMP reply header parser assertion macros
// Concurrent checks sampled on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ICMP_REPLY_HEADER_PARSER_CORE_ASSERT_SVH
`define ICMP_REPLY_HEADER_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define RHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/icmp_rhp_pkg.sv -----
// ----------------------------------------------------------------------------
// ICMP reply header parser package
// Shared constants, reason codes and the structs passed between the stages.
// ----------------------------------------------------------------------------
package icmp_rhp_pkg;

  localparam int unsigned STAMP_BYTES_DEF      = 16;
  localparam int unsigned MAX_PACKET_BYTES_DEF = 65535;

  localparam int unsigned ICMP_HDR_BYTES = 8;
  localparam int unsigned IP_MIN_BYTES   = 20;
  localparam int unsigned TTL_POS        = 8;
  localparam int unsigned ID_FIELD_POS   = 4;
  localparam logic [7:0]  ECHO_REPLY_TYPE = 8'd0;

  // Position arithmetic width: holds any packet offset plus header sums.
  localparam int unsigned CMP_W = 17;
  localparam int unsigned LEN_W = 16;

  localparam int unsigned RESULT_W = 221;
  localparam int unsigned TDATA_W  = 224;

  typedef enum logic [2:0] {
    REASON_OK          = 3'd0,
    REASON_OUTER_SHORT = 3'd1,
    REASON_INNER_SHORT = 3'd2,
    REASON_ID_MISMATCH = 3'd3,
    REASON_STAMP_SHORT = 3'd4
  } reason_t;

  // Take and last flags of one byte moving from the input register into the capture and verdict logic.
  typedef struct packed {
    logic take;
    logic last;
  } step_t;

  // Packet state after the current byte has been folded in.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [3:0]       outer_words;
    logic [3:0]       inner_words;
    logic [7:0]       ttl;
    logic [7:0]       icmp_type;
    logic [7:0]       icmp_code;
    logic [63:0]      ids_seqs;
    logic [63:0]      stamp_seconds;
    logic [63:0]      stamp_micros;
  } packet_t;

  // Result transaction; last member sits in the lowest bits.
  typedef struct packed {
    logic [63:0] stamp_micros;
    logic [63:0] stamp_seconds;
    logic [15:0] inner_sequence;
    logic [15:0] reply_sequence;
    logic [15:0] reply_identifier;
    logic [15:0] icmp_length;
    logic [7:0]  hop_ttl;
    logic [7:0]  icmp_code;
    logic [7:0]  icmp_type;
    logic        is_echo_reply;
    reason_t     reject_reason;
    logic        accepted;
  } result_t;

endpackage

// ----- rtl/core/icmp_rhp_capture.sv -----
// ----------------------------------------------------------------------------
// ICMP reply header parser byte capture
// Tracks the byte offset and picks header fields and stamp bytes out of the stream.
// ----------------------------------------------------------------------------
`include "icmp_reply_header_parser_core_assert.svh"

module icmp_rhp_capture #(
  parameter int unsigned STAMP_BYTES      = icmp_rhp_pkg::STAMP_BYTES_DEF,
  parameter int unsigned MAX_PACKET_BYTES = icmp_rhp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  icmp_rhp_pkg::step_t   step,
  input  logic [7:0]            data,
  output icmp_rhp_pkg::packet_t pkt
);

  localparam int unsigned OFFSET_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned CMP_W    = icmp_rhp_pkg::CMP_W;

  logic [OFFSET_W-1:0] offset, offset_next;
  logic [3:0]          outer_words, outer_words_next;
  logic [3:0]          inner_words, inner_words_next;
  logic [7:0]          ttl, ttl_next;
  logic [15:0]         type_code, type_code_next;
  logic [63:0]         ids_seqs, ids_seqs_next;
  logic [127:0]        stamp, stamp_next;

  logic             take;
  logic             in_outer_ids, in_inner_ids, in_stamp;
  logic [CMP_W-1:0] p, h, i, j, s;
  logic [CMP_W-1:0] outer_d, inner_d, stamp_d;

  always_comb begin
    take = step.take && (offset < OFFSET_W'(MAX_PACKET_BYTES));
    p    = CMP_W'(offset);

    outer_words_next = (take && offset == '0) ? data[3:0] : outer_words;
    h = CMP_W'({outer_words_next, 2'b00});

    ttl_next = (take && p == CMP_W'(icmp_rhp_pkg::TTL_POS)) ? data : ttl;

    type_code_next = type_code;
    if (take && p == h) begin
      type_code_next[15:8] = data;
    end
    if (take && p == h + CMP_W'(1)) begin
      type_code_next[7:0] = data;
    end

    // Outer identifier and sequence land in lanes 7..4, high byte first.
    outer_d      = p - (h + CMP_W'(icmp_rhp_pkg::ID_FIELD_POS));
    in_outer_ids = take && (p >= h + CMP_W'(icmp_rhp_pkg::ID_FIELD_POS))
                   && (p < h + CMP_W'(icmp_rhp_pkg::ICMP_HDR_BYTES));

    i = h + CMP_W'(icmp_rhp_pkg::ICMP_HDR_BYTES);
    inner_words_next = (take && p == i) ? data[3:0] : inner_words;
    j = i + CMP_W'({inner_words_next, 2'b00});

    // Inner identifier and sequence land in lanes 3..0.
    inner_d      = p - (j + CMP_W'(icmp_rhp_pkg::ID_FIELD_POS));
    in_inner_ids = take && (p >= j + CMP_W'(icmp_rhp_pkg::ID_FIELD_POS))
                   && (p < j + CMP_W'(icmp_rhp_pkg::ICMP_HDR_BYTES));

    ids_seqs_next = ids_seqs;
    for (int l = 0; l < 4; l++) begin
      if (in_outer_ids && outer_d[1:0] == 2'(3 - l)) begin
        ids_seqs_next[(l + 4) * 8 +: 8] = data;
      end
      if (in_inner_ids && inner_d[1:0] == 2'(3 - l)) begin
        ids_seqs_next[l * 8 +: 8] = data;
      end
    end

    // Stamp follows the echo header directly, or the quoted inner ICMP header.
    s = (type_code_next[15:8] == icmp_rhp_pkg::ECHO_REPLY_TYPE)
        ? i : j + CMP_W'(icmp_rhp_pkg::ICMP_HDR_BYTES);
    stamp_d  = p - s;
    in_stamp = take && (p >= s) && (stamp_d < CMP_W'(STAMP_BYTES));

    stamp_next = stamp;
    for (int l = 0; l < 16; l++) begin
      if (in_stamp && stamp_d[3:0] == 4'(l)) begin
        stamp_next[l * 8 +: 8] = stamp[l * 8 +: 8] | data;
      end
    end

    offset_next = take ? offset + OFFSET_W'(1) : offset;

    pkt.len           = icmp_rhp_pkg::LEN_W'(offset_next);
    pkt.outer_words   = outer_words_next;
    pkt.inner_words   = inner_words_next;
    pkt.ttl           = ttl_next;
    pkt.icmp_type     = type_code_next[15:8];
    pkt.icmp_code     = type_code_next[7:0];
    pkt.ids_seqs      = ids_seqs_next;
    pkt.stamp_seconds = stamp_next[63:0];
    pkt.stamp_micros  = stamp_next[127:64];
  end

  always_ff @(posedge clk) begin
    if (rst || (step.take && step.last)) begin
      offset      <= '0;
      outer_words <= '0;
      inner_words <= '0;
      ttl         <= '0;
      type_code   <= '0;
      ids_seqs    <= '0;
      stamp       <= '0;
    end else if (step.take) begin
      offset      <= offset_next;
      outer_words <= outer_words_next;
      inner_words <= inner_words_next;
      ttl         <= ttl_next;
      type_code   <= type_code_next;
      ids_seqs    <= ids_seqs_next;
      stamp       <= stamp_next;
    end
  end

  `RHP_ASSERT_NOW(a_offset_bounded, 1'b1, offset <= OFFSET_W'(MAX_PACKET_BYTES), "offset overrun")
  `RHP_ASSERT_NEXT(a_clear_after_last, step.take && step.last, offset == '0 && stamp == '0 && ids_seqs == '0, "state not cleared after last byte")

endmodule

// ----- rtl/core/icmp_rhp_verdict.sv -----
// ----------------------------------------------------------------------------
// ICMP reply header parser verdict
// Runs the length and identifier checks and holds the result transaction.
// ----------------------------------------------------------------------------
`include "icmp_reply_header_parser_core_assert.svh"

module icmp_rhp_verdict #(
  parameter int unsigned STAMP_BYTES = icmp_rhp_pkg::STAMP_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  icmp_rhp_pkg::step_t   step,
  input  icmp_rhp_pkg::packet_t pkt,
  input  logic [15:0]           own_identifier,
  input  logic                  out_ready,
  output logic                  out_valid,
  output icmp_rhp_pkg::result_t result
);

  localparam int unsigned CMP_W = icmp_rhp_pkg::CMP_W;

  icmp_rhp_pkg::result_t result_next;
  icmp_rhp_pkg::reason_t reason;
  logic                  load;
  logic                  echo;
  logic [CMP_W-1:0]      len, h, i, j;
  logic [15:0]           outer_id, outer_seq, inner_id, inner_seq;

  assign load = step.take && step.last;

  always_comb begin
    len  = CMP_W'(pkt.len);
    h    = CMP_W'({pkt.outer_words, 2'b00});
    i    = h + CMP_W'(icmp_rhp_pkg::ICMP_HDR_BYTES);
    j    = i + CMP_W'({pkt.inner_words, 2'b00});
    echo = (pkt.icmp_type == icmp_rhp_pkg::ECHO_REPLY_TYPE);

    outer_id  = pkt.ids_seqs[63:48];
    outer_seq = pkt.ids_seqs[47:32];
    inner_id  = pkt.ids_seqs[31:16];
    inner_seq = pkt.ids_seqs[15:0];

    result_next = '0;
    reason      = icmp_rhp_pkg::REASON_OK;

    if (len < CMP_W'(icmp_rhp_pkg::IP_MIN_BYTES + icmp_rhp_pkg::ICMP_HDR_BYTES)
        || i > len) begin
      // Outer headers short: everything but the reason stays zero.
      result_next.reject_reason = icmp_rhp_pkg::REASON_OUTER_SHORT;
    end else begin
      if (echo) begin
        reason = (outer_id != own_identifier) ? icmp_rhp_pkg::REASON_ID_MISMATCH
                                              : icmp_rhp_pkg::REASON_OK;
        result_next.reply_identifier = outer_id;
      end else if (i + CMP_W'(icmp_rhp_pkg::IP_MIN_BYTES) > len
                   || j + CMP_W'(icmp_rhp_pkg::ICMP_HDR_BYTES) > len) begin
        reason = icmp_rhp_pkg::REASON_INNER_SHORT;
      end else begin
        if (inner_id != own_identifier) begin
          reason = icmp_rhp_pkg::REASON_ID_MISMATCH;
        end else if (j + CMP_W'(icmp_rhp_pkg::ICMP_HDR_BYTES + STAMP_BYTES) > len) begin
          reason = icmp_rhp_pkg::REASON_STAMP_SHORT;
        end
        result_next.reply_identifier = inner_id;
        result_next.inner_sequence   = inner_seq;
      end

      result_next.accepted       = (reason == icmp_rhp_pkg::REASON_OK);
      result_next.reject_reason  = reason;
      result_next.is_echo_reply  = echo;
      result_next.icmp_type      = pkt.icmp_type;
      result_next.icmp_code      = pkt.icmp_code;
      result_next.hop_ttl        = pkt.ttl;
      result_next.icmp_length    = icmp_rhp_pkg::LEN_W'(len - h);
      result_next.reply_sequence = outer_seq;
      if (reason == icmp_rhp_pkg::REASON_OK) begin
        result_next.stamp_seconds = pkt.stamp_seconds;
        result_next.stamp_micros  = pkt.stamp_micros;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

  `RHP_ASSERT_NEXT(a_load_shows_result, load, out_valid, "verdict lost after last byte")
  `RHP_ASSERT_NOW(a_reject_no_stamp, out_valid && !result.accepted, result.stamp_seconds == '0 && result.stamp_micros == '0, "stamp leaked on reject")
  `RHP_ASSERT_NOW(a_outer_short_blank, out_valid && result.reject_reason == icmp_rhp_pkg::REASON_OUTER_SHORT, result.icmp_length == '0 && result.hop_ttl == '0 && result.reply_identifier == '0 && !result.accepted, "outer-short verdict not blank")

endmodule

// ----- rtl/core/icmp_reply_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// ICMP reply header parser core
// Parses a received IPv4 packet byte by byte and gives one verdict per packet.
// ----------------------------------------------------------------------------
// The block takes one packet byte per transaction on the s_axis side, with
// s_axis_tlast on the final byte, and sustains one byte per clock. Each byte
// sits in an input register, where short capture logic folds it into the
// packet state (IHL, TTL, outer and quoted ICMP headers, 16 stamp bytes). On
// the last byte the same cycle runs the length and identifier checks and
// loads one result transaction into the output register, so a verdict
// reaches m_axis through the input register and then the output register.
// The input side stalls only when a last byte meets a verdict that has not
// yet been taken; ordinary bytes keep flowing. There is no clearing pass
// after reset. The user must write own_identifier through
// cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
// Bytes beyond MAX_PACKET_BYTES are dropped and the length holds at that value.
module icmp_reply_header_parser_core #(
  parameter int unsigned STAMP_BYTES      = icmp_rhp_pkg::STAMP_BYTES_DEF,
  parameter int unsigned MAX_PACKET_BYTES = icmp_rhp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration: own_identifier.
  input  logic                              cfg_wr_en,
  input  logic [15:0]                       cfg_wr_data,
  // Input stream. tdata: packet_byte[7:0]. tlast: last_byte.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,
  input  logic                              s_axis_tlast,
  // Result stream. tdata from bit 0: accepted, reject_reason[2:0],
  // is_echo_reply, icmp_type[7:0], icmp_code[7:0], hop_ttl[7:0],
  // icmp_length[15:0], reply_identifier[15:0], reply_sequence[15:0],
  // inner_sequence[15:0], stamp_seconds[63:0], stamp_micros[63:0], zero pad.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [icmp_rhp_pkg::TDATA_W-1:0]  m_axis_tdata
);

  logic [15:0] own_identifier;

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;

  icmp_rhp_pkg::step_t   step;
  icmp_rhp_pkg::packet_t pkt;
  icmp_rhp_pkg::result_t result;

  // A held byte moves on unless it is a last byte and the previous verdict
  // is still waiting downstream.
  assign advance       = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  assign step.take = advance;
  assign step.last = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_identifier <= '0;
    end else if (cfg_wr_en) begin
      own_identifier <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // Hold payload while the byte stalls.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  icmp_rhp_capture #(
    .STAMP_BYTES      (STAMP_BYTES),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_capture (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .data (in_byte),
    .pkt  (pkt)
  );

  icmp_rhp_verdict #(
    .STAMP_BYTES (STAMP_BYTES)
  ) u_verdict (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .pkt            (pkt),
    .own_identifier (own_identifier),
    .out_ready      (m_axis_tready),
    .out_valid      (m_axis_tvalid),
    .result         (result)
  );

  assign m_axis_tdata = {
    {(icmp_rhp_pkg::TDATA_W - icmp_rhp_pkg::RESULT_W){1'b0}}, result
  };

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// ICMP reply header parser testbench
// Feeds received IPv4 packets one byte per transaction into the parser and
// compares every verdict with a local prediction of the outer and quoted
// header captures, the length checks and the identifier checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import icmp_rhp_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int TIMEOUT_NS = 10_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 140;
  localparam int PHASE_FRAMES = 3;
  localparam int MAX_PRINTS = 40;

  // Predicts one verdict per packet and holds the verdicts still to arrive.
  class reply_verdict_model;
    logic [15:0] own_id;
    int unsigned offset;
    logic [3:0]  outer_words;
    logic [3:0]  inner_words;
    logic [7:0]  ttl;
    logic [15:0] type_code;
    logic [63:0] ids_seqs;
    logic [63:0] stamp [2];
    result_t     verdicts [$];
    int unsigned n_checked;
    int unsigned mismatches;

    function new();
      own_id = '0;
      n_checked = 0;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      offset = 0;
      outer_words = '0;
      inner_words = '0;
      ttl = '0;
      type_code = '0;
      ids_seqs = '0;
      stamp[0] = '0;
      stamp[1] = '0;
    endfunction

    // Match one byte against every field position; overlapping headers may
    // let a single byte fill several fields.
    function void fold_byte(int unsigned p, logic [7:0] b);
      int unsigned h, i, j, s, k;
      if (p == 0) outer_words = b[3:0];
      h = outer_words * 4;
      if (p == TTL_POS) ttl = b;
      if (p == h) type_code[15:8] = b;
      if (p == h + 1) type_code[7:0] = b;
      if (p >= h + 4 && p < h + 8) ids_seqs[(7 - (p - h - 4)) * 8 +: 8] = b;
      i = h + ICMP_HDR_BYTES;
      if (p == i) inner_words = b[3:0];
      j = i + inner_words * 4;
      if (p >= j + 4 && p < j + 8) ids_seqs[(3 - (p - j - 4)) * 8 +: 8] = b;
      s = (type_code[15:8] == ECHO_REPLY_TYPE) ? i : j + ICMP_HDR_BYTES;
      if (p >= s && p < s + STAMP_BYTES_DEF) begin
        k = (p - s) & 15;
        stamp[k >> 3][(k & 7) * 8 +: 8] = stamp[k >> 3][(k & 7) * 8 +: 8] | b;
      end
    endfunction

    // Note one accepted input transaction; the last byte queues a verdict.
    function void note_byte(logic [7:0] b, logic last);
      int unsigned len, h, i, j;
      logic [15:0] outer_id, outer_seq, inner_id, inner_seq;
      result_t r;
      if (offset < MAX_PACKET_BYTES_DEF) begin
        fold_byte(offset, b);
        offset++;
      end
      if (!last) return;
      len = offset;
      h = outer_words * 4;
      i = h + ICMP_HDR_BYTES;
      j = i + inner_words * 4;
      outer_id = ids_seqs[63:48];
      outer_seq = ids_seqs[47:32];
      inner_id = ids_seqs[31:16];
      inner_seq = ids_seqs[15:0];
      r = '0;
      if (len < IP_MIN_BYTES + ICMP_HDR_BYTES || h + ICMP_HDR_BYTES > len) begin
        r.reject_reason = REASON_OUTER_SHORT;
      end else begin
        r.is_echo_reply = (type_code[15:8] == ECHO_REPLY_TYPE);
        if (r.is_echo_reply) begin
          r.reject_reason = (outer_id != own_id) ? REASON_ID_MISMATCH : REASON_OK;
          r.reply_identifier = outer_id;
        end else if (i + IP_MIN_BYTES > len || j + ICMP_HDR_BYTES > len) begin
          r.reject_reason = REASON_INNER_SHORT;
        end else begin
          if (inner_id != own_id)
            r.reject_reason = REASON_ID_MISMATCH;
          else if (j + ICMP_HDR_BYTES + STAMP_BYTES_DEF > len)
            r.reject_reason = REASON_STAMP_SHORT;
          else
            r.reject_reason = REASON_OK;
          r.reply_identifier = inner_id;
          r.inner_sequence = inner_seq;
        end
        r.accepted = (r.reject_reason == REASON_OK);
        r.icmp_type = type_code[15:8];
        r.icmp_code = type_code[7:0];
        r.hop_ttl = ttl;
        r.icmp_length = 16'(len - h);
        r.reply_sequence = outer_seq;
        if (r.accepted) begin
          r.stamp_seconds = stamp[0];
          r.stamp_micros = stamp[1];
        end
      end
      verdicts.push_back(r);
      clear();
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("%0t verdict %0d: %s", $time, n_checked, what);
    endtask

    task same(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Compare one result transaction with the oldest predicted verdict.
    task check_result(logic [TDATA_W-1:0] data);
      result_t got, want;
      got = result_t'(data[RESULT_W-1:0]);
      n_checked++;
      if (verdicts.size() == 0) begin
        report("verdict with no packet pending");
        return;
      end
      want = verdicts.pop_front();
      same("accepted", 64'(got.accepted), 64'(want.accepted));
      same("reject_reason", 64'(got.reject_reason), 64'(want.reject_reason));
      same("is_echo_reply", 64'(got.is_echo_reply), 64'(want.is_echo_reply));
      same("icmp_type", 64'(got.icmp_type), 64'(want.icmp_type));
      same("icmp_code", 64'(got.icmp_code), 64'(want.icmp_code));
      same("hop_ttl", 64'(got.hop_ttl), 64'(want.hop_ttl));
      same("icmp_length", 64'(got.icmp_length), 64'(want.icmp_length));
      same("reply_identifier", 64'(got.reply_identifier), 64'(want.reply_identifier));
      same("reply_sequence", 64'(got.reply_sequence), 64'(want.reply_sequence));
      same("inner_sequence", 64'(got.inner_sequence), 64'(want.inner_sequence));
      same("stamp_seconds", got.stamp_seconds, want.stamp_seconds);
      same("stamp_micros", got.stamp_micros, want.stamp_micros);
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [15:0]         cfg_wr_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // packet_byte[7:0]
  logic                s_axis_tlast = 1'b0; // last_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // accepted, reject_reason[2:0], is_echo_reply, icmp_type[7:0], icmp_code[7:0],
  // hop_ttl[7:0], icmp_length[15:0], reply_identifier[15:0], reply_sequence[15:0],
  // inner_sequence[15:0], stamp_seconds[63:0], stamp_micros[63:0], zero pad
  logic [TDATA_W-1:0]  m_axis_tdata;

  reply_verdict_model board = new();

  logic [7:0]  frame [$];     // packet bytes about to be sent
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;
  int unsigned hold_asks = 0; // bumped by the sender, served by the receiver

  icmp_reply_header_parser_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Offer one byte, with a random gap unless the sender is calm, and hold it
  // until the parser takes the transaction.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!src_calm && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_byte(b, last);
  endtask

  task automatic send_frame();
    int unsigned k;
    for (k = 0; k < frame.size(); k++) send_byte(frame[k], k == frame.size() - 1);
  endtask

  // Drop valid and wait until every verdict is in.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_identifier(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    board.own_id = v;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [3:0] pick_ihl();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return 4'd5;
    if (r < 95) return 4'($urandom_range(6, 15));
    return 4'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] pick_error_type();
    case ($urandom_range(0, 3))
      0: return 8'd3;
      1: return 8'd11;
      2: return 8'd12;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic put_byte(input int unsigned pos, input logic [7:0] v);
    if (pos < frame.size()) frame[pos] = v;
  endtask

  task automatic build_fill(input int unsigned len, input bit random_fill,
                            input logic [7:0] v);
    int unsigned k;
    frame.delete();
    for (k = 0; k < len; k++) frame.push_back(random_fill ? 8'($urandom) : v);
  endtask

  // Build a reply of total_len bytes around random content. Write byte 0
  // last so the IHL survives any overlap with the ICMP header.
  task automatic build_reply(input bit echo, input logic [3:0] ihl,
                             input logic [3:0] inner_ihl, input bit id_good,
                             input int unsigned total_len);
    int unsigned h, i, j;
    logic [15:0] id;
    logic [3:0]  version;
    h = ihl * 4;
    i = h + ICMP_HDR_BYTES;
    j = i + inner_ihl * 4;
    id = id_good ? board.own_id : ~board.own_id;
    version = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h4;
    build_fill(total_len, 1'b1, 8'h00);
    if (!echo) begin
      put_byte(i, {4'h4, inner_ihl});
      put_byte(j, 8'd8);
      put_byte(j + 4, id[15:8]);
      put_byte(j + 5, id[7:0]);
      put_byte(h, pick_error_type());
    end else begin
      put_byte(h, ECHO_REPLY_TYPE);
      put_byte(h + 4, id[15:8]);
      put_byte(h + 5, id[7:0]);
    end
    put_byte(0, {version, ihl});
  endtask

  // Mostly well-formed replies with random content; the rest is noise.
  task automatic random_frame();
    int unsigned r, full;
    bit echo;
    logic [3:0] ihl, inner_ihl;
    r = $urandom_range(0, 99);
    if (r >= 80) begin
      build_fill($urandom_range(1, 48), 1'b1, 8'h00);
      if ($urandom_range(0, 1) == 1) put_byte(0, 8'h45);
    end else begin
      echo = (r < 40);
      ihl = pick_ihl();
      inner_ihl = pick_ihl();
      full = ihl * 4 + ICMP_HDR_BYTES + STAMP_BYTES_DEF;
      if (!echo) full = full + inner_ihl * 4 + ICMP_HDR_BYTES;
      if ($urandom_range(0, 99) < 75) full = full + $urandom_range(0, 12);
      else full = $urandom_range(1, full + 4);
      build_reply(echo, ihl, inner_ihl, $urandom_range(0, 99) < 85, full);
    end
  endtask

  // Receiver: check each result transaction, stall at random, and serve a
  // long hold-off whenever the sender asks for one.
  initial begin : sink
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= sink_calm || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] phase_ids [4];
    int unsigned phase, phase_bytes, phase_frames;
    phase_ids[0] = 16'hFFFF;
    phase_ids[1] = 16'h0000;
    phase_ids[2] = 16'($urandom);
    phase_ids[3] = 16'($urandom);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed packets run with the identifier still at its reset value.
    build_reply(1'b1, 4'd5, 4'd5, 1'b1, 44);    send_frame(); // echo, accepted
    build_reply(1'b1, 4'd5, 4'd5, 1'b0, 44);    send_frame(); // echo, wrong id
    build_reply(1'b1, 4'd5, 4'd5, 1'b1, 30);    send_frame(); // echo, stamp cut off
    build_reply(1'b1, 4'd5, 4'd5, 1'b1, 28);    send_frame(); // minimum length
    build_reply(1'b1, 4'd5, 4'd5, 1'b1, 27);    send_frame(); // one byte too short
    build_reply(1'b1, 4'd15, 4'd5, 1'b1, 67);   send_frame(); // ICMP past the end
    build_reply(1'b1, 4'd15, 4'd5, 1'b1, 68);   send_frame(); // ICMP just fits
    build_reply(1'b0, 4'd5, 4'd5, 1'b1, 72);    send_frame(); // error, accepted
    build_reply(1'b0, 4'd5, 4'd5, 1'b0, 72);    send_frame(); // inner id mismatch
    build_reply(1'b0, 4'd5, 4'd5, 1'b1, 60);    send_frame(); // stamp short
    build_reply(1'b0, 4'd5, 4'd5, 1'b1, 40);    send_frame(); // inner IP short
    build_reply(1'b0, 4'd5, 4'd2, 1'b1, 56);    send_frame(); // tiny inner IHL
    build_reply(1'b0, 4'd15, 4'd15, 1'b1, 152); send_frame(); // largest headers
    build_reply(1'b1, 4'd1, 4'd5, 1'b1, 30);    send_frame(); // overlapping headers
    build_fill(30, 1'b0, 8'h00);                send_frame(); // all zero bytes
    build_fill(30, 1'b0, 8'hFF);                send_frame(); // all one bytes
    build_fill(1, 1'b1, 8'h00);                 send_frame(); // single byte

    for (phase = 0; phase < 4; phase++) begin
      drain();
      write_identifier(phase_ids[phase]);
      src_calm = (phase == 1);
      sink_calm = (phase == 2);
      phase_bytes = 0;
      phase_frames = 0;
      while (phase_bytes < PHASE_BYTES || phase_frames < PHASE_FRAMES) begin
        random_frame();
        send_frame();
        phase_bytes += frame.size();
        phase_frames++;
        // Stall the receiver while the sender keeps streaming packets.
        if (phase == 1 && phase_frames == 1) hold_asks++;
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (board.mismatches == 0 && board.verdicts.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("testbench NOT OK");
    $finish;
  end

endmodule
